@@ hw/rtl/sbda_pkg.sv @@
`default_nettype none

package sbda_pkg;

   localparam logic [5:0] CHAR_MINUS = 6'd45;
   localparam logic [5:0] CHAR_ZERO  = 6'd48;

   typedef struct packed {
      logic valid;
      logic negative;
   } conv_stat_type;

endpackage : sbda_pkg

`default_nettype wire

@@ hw/rtl/sbda_conv.sv @@
`default_nettype none

module sbda_conv #(
   parameter int VALUE_WIDTH = 32,
   parameter int NUM_DIGITS  = 10,
   parameter int IDX_WIDTH   = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        enable,
   input  wire logic                        in_valid,
   input  wire logic [VALUE_WIDTH-1:0]      in_value,
   output sbda_pkg::conv_stat_type          out_stat,
   output logic      [4*NUM_DIGITS-1:0]     out_bcd,
   output logic      [IDX_WIDTH-1:0]        out_lead
);

   import sbda_pkg::*;

   localparam int BCD_WIDTH = 4 * NUM_DIGITS;
   localparam int BITS_PER_STAGE = 4;
   localparam int NUM_STAGES = (VALUE_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

   logic                   vld_ff [0:NUM_STAGES];
   logic                   neg_ff [0:NUM_STAGES];
   logic [BCD_WIDTH-1:0]   bcd_ff [0:NUM_STAGES];
   logic [VALUE_WIDTH-1:0] bin_ff [0:NUM_STAGES];
   logic [BCD_WIDTH-1:0]   bcd_in [1:NUM_STAGES];
   logic [VALUE_WIDTH-1:0] bin_in [1:NUM_STAGES];
   logic [VALUE_WIDTH-1:0] mag_in;
   conv_stat_type          stat_ff;
   logic [BCD_WIDTH-1:0]   obcd_ff;
   logic [IDX_WIDTH-1:0]   lead_ff;
   logic [IDX_WIDTH-1:0]   lead_in;

   // The magnitude is formed unsigned so that the most negative value is exact.
   assign mag_in = in_value[VALUE_WIDTH-1] ? (~in_value + VALUE_WIDTH'(1)) : in_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= in_valid;
      end
      if (enable) begin
         neg_ff[0] <= in_value[VALUE_WIDTH-1];
         bcd_ff[0] <= '0;
         bin_ff[0] <= mag_in;
      end
   end

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_dabble
      always_comb begin
         logic [BCD_WIDTH-1:0]   b;
         logic [VALUE_WIDTH-1:0] m;
         b = bcd_ff[s];
         m = bin_ff[s];
         for (int k = 0; k < BITS_PER_STAGE; k++) begin
            if (s * BITS_PER_STAGE + k < VALUE_WIDTH) begin
               for (int d = 0; d < NUM_DIGITS; d++) begin
                  if (b[4*d +: 4] >= 4'd5) begin
                     b[4*d +: 4] = b[4*d +: 4] + 4'd3;
                  end
               end
               b = {b[BCD_WIDTH-2:0], m[VALUE_WIDTH-1]};
               m = {m[VALUE_WIDTH-2:0], 1'b0};
            end
         end
         bcd_in[s+1] = b;
         bin_in[s+1] = m;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (enable) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (enable) begin
            neg_ff[s+1] <= neg_ff[s];
            bcd_ff[s+1] <= bcd_in[s+1];
            bin_ff[s+1] <= bin_in[s+1];
         end
      end
   end

   always_comb begin
      lead_in = '0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[NUM_STAGES][4*d +: 4] != 4'd0) begin
            lead_in = IDX_WIDTH'(d);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff.valid <= 1'b0;
      end else if (enable) begin
         stat_ff.valid <= vld_ff[NUM_STAGES];
      end
      if (enable) begin
         stat_ff.negative <= neg_ff[NUM_STAGES];
         obcd_ff          <= bcd_ff[NUM_STAGES];
         lead_ff          <= lead_in;
      end
   end

   assign out_stat = stat_ff;
   assign out_bcd  = obcd_ff;
   assign out_lead = lead_ff;

endmodule : sbda_conv

`default_nettype wire

@@ hw/rtl/signed_binary_to_decimal_ascii_unit.sv @@
`default_nettype none

// Converts a signed VALUE_WIDTH-bit integer, taken from the low bits of req_tdata, into its
// decimal text in ASCII, one character per beat, most significant first, with a leading '-'
// for negative values, no leading zeros and rsp_tlast on the final character. A value gives
// one to eleven characters at the default width, sent one character per cycle while
// rsp_tready is held high; the output serialiser sets that rate. Conversion runs through a
// shift-and-add-three pipeline of 2 + VALUE_WIDTH/4 (rounded up) register stages (10 at 32
// bits), which advances as a whole whenever the serialiser is empty or sends its final
// character, so a new value is taken in the same cycle that the previous value's last
// character leaves.
module signed_binary_to_decimal_ascii_unit #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // value[31:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // character[5:0], zero[7:6]
   output logic             rsp_tlast
);

   import sbda_pkg::*;

   localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 3) / 10 + 1;
   localparam int IDX_WIDTH  = $clog2(NUM_DIGITS);
   localparam int BCD_WIDTH  = 4 * NUM_DIGITS;

   conv_stat_type          conv_stat;
   logic [BCD_WIDTH-1:0]   conv_bcd;
   logic [IDX_WIDTH-1:0]   conv_lead;
   logic                   advance;

   logic                   ser_vld_ff;
   logic                   ser_vld_in;
   logic                   ser_minus_ff;
   logic                   ser_minus_in;
   logic [BCD_WIDTH-1:0]   ser_bcd_ff;
   logic [BCD_WIDTH-1:0]   ser_bcd_in;
   logic [IDX_WIDTH-1:0]   ser_idx_ff;
   logic [IDX_WIDTH-1:0]   ser_idx_in;
   logic [3:0]             cur_digit;
   logic [5:0]             cur_char;

   sbda_conv #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .NUM_DIGITS  (NUM_DIGITS),
      .IDX_WIDTH   (IDX_WIDTH)
   ) u_conv (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .in_valid (req_tvalid),
      .in_value (req_tdata[VALUE_WIDTH-1:0]),
      .out_stat (conv_stat),
      .out_bcd  (conv_bcd),
      .out_lead (conv_lead)
   );

   assign cur_digit  = ser_bcd_ff[4*ser_idx_ff +: 4];
   assign cur_char   = ser_minus_ff ? CHAR_MINUS : (CHAR_ZERO + {2'b00, cur_digit});
   assign rsp_tvalid = ser_vld_ff;
   assign rsp_tdata  = {2'b00, cur_char};
   assign rsp_tlast  = !ser_minus_ff && (ser_idx_ff == '0);
   assign advance    = !ser_vld_ff || (rsp_tready && rsp_tlast);
   assign req_tready = advance;

   always_comb begin
      ser_vld_in   = ser_vld_ff;
      ser_minus_in = ser_minus_ff;
      ser_bcd_in   = ser_bcd_ff;
      ser_idx_in   = ser_idx_ff;
      if (advance) begin
         ser_vld_in   = conv_stat.valid;
         ser_minus_in = conv_stat.negative;
         ser_bcd_in   = conv_bcd;
         ser_idx_in   = conv_lead;
      end else if (rsp_tready) begin
         if (ser_minus_ff) begin
            ser_minus_in = 1'b0;
         end else begin
            ser_idx_in = ser_idx_ff - IDX_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff <= 1'b0;
      end else begin
         ser_vld_ff <= ser_vld_in;
      end
      ser_minus_ff <= ser_minus_in;
      ser_bcd_ff   <= ser_bcd_in;
      ser_idx_ff   <= ser_idx_in;
   end

   // A negative value always has a non-zero magnitude.
   assert property (@(posedge clock) disable iff (reset)
      (ser_vld_ff && ser_minus_ff) |-> (ser_bcd_ff != '0))
      else $error("minus sign pending with zero magnitude");

   assert property (@(posedge clock) disable iff (reset)
      ser_vld_ff |-> (ser_idx_ff <= IDX_WIDTH'(NUM_DIGITS - 1)))
      else $error("digit index out of range");

   assert property (@(posedge clock) disable iff (reset)
      ser_vld_ff |-> (cur_digit <= 4'd9))
      else $error("digit is not a decimal digit");

   // A digit is only stepped past after it has been sent.
   assert property (@(posedge clock) disable iff (reset)
      (ser_vld_ff && !rsp_tready) |=> (ser_vld_ff && $stable(ser_idx_ff)
                                       && $stable(ser_minus_ff)))
      else $error("serialiser moved without a beat");

endmodule : signed_binary_to_decimal_ascii_unit

`default_nettype wire
